// ----- rtl/core/ber_pkg.sv -----
`default_nettype none

package ber_pkg;

  localparam int unsigned RowW        = 64;
  localparam int unsigned CfgW        = 7;
  localparam int unsigned MaxWidthDef = 64;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [CfgW-1:0] FrameWidthRst = CfgW'(64);

  typedef struct packed {
    logic [RowW-1:0] pixel_row;
    logic            last_row;
  } ber_in_t;

  typedef struct packed {
    logic [RowW-1:0] eroded_row;
    logic            frame_end;
  } ber_out_t;

  // Queue entry control: emit_row carries an eroded row, last adds the closing zero beat
  typedef struct packed {
    logic emit_row;
    logic last;
  } ber_cmd_t;

  localparam int unsigned CmdW = $bits(ber_cmd_t);

endpackage

`default_nettype wire

// ----- rtl/core/binary_erosion_3x3_rows_core.sv -----
// 3x3 binary erosion of a bilevel image streamed one row per input beat. A set
// pixel survives only when all eight neighbours are set; pixels outside the
// image, and columns at or beyond frame_width (saturated to MAX_WIDTH), count
// as clear and read back as 0. The first row of a frame gives no output beat,
// each later row gives the eroded row above it, and the row flagged last_row
// also gives an all-zero beat with frame_end set, so a frame of N rows yields
// N output beats. The front stage takes one row every cycle while the queue is
// not full and computes the erosion combinationally; a two-entry queue feeds a
// registered output stage; each result passes the queue, then the output register.
// The sustained rate is one row per cycle while the receiver is ready, set by the
// output stage issuing one beat per cycle. Write frame_width between frames.
`default_nettype none

module binary_erosion_3x3_rows_core import ber_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MaxWidthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  input  wire ber_in_t         in_data_i,
  output      logic            out_valid_o,
  input  wire logic            out_ready_i,
  output      ber_out_t        out_data_o
);

  localparam int unsigned EntryW = CmdW + MAX_WIDTH;
  localparam int unsigned LvlW   = $clog2(QueueDepth + 1);

  logic                 push, pop, full, empty, pend_last;
  ber_cmd_t             push_cmd, pop_cmd;
  logic [MAX_WIDTH-1:0] push_row, pop_row;
  logic [LvlW-1:0]      level;

  ber_front #(
    .MaxWidth (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .push_row_o  (push_row)
  );

  ber_fifo #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_cmd, push_row}),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  ({pop_cmd, pop_row}),
    .empty_o     (empty),
    .level_o     (level)
  );

  ber_back #(
    .MaxWidth (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .pop_cmd_i   (pop_cmd),
    .pop_row_i   (pop_row),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .pend_last_o (pend_last)
  );

  a_end_beat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.eroded_row == '0)
    else $error("frame end beat carries pixels");

  a_pend_after_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_last |-> out_valid_o && !out_data_o.frame_end)
    else $error("closing beat pending without a row beat in flight");

  a_queue_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= LvlW'(QueueDepth))
    else $error("queue level out of range");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("entry pushed into full queue");

endmodule

`default_nettype wire

// ----- rtl/core/ber_front.sv -----
`default_nettype none

module ber_front import ber_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire ber_in_t             in_data_i,
  input  wire logic                full_i,
  output      logic                push_o,
  output      ber_cmd_t            push_cmd_o,
  output      logic [MaxWidth-1:0] push_row_o
);

  logic [CfgW-1:0]     width_q;
  logic [CfgW-1:0]     eff_width;
  logic [MaxWidth-1:0] mask;
  logic [MaxWidth-1:0] row;
  logic [MaxWidth-1:0] upper_q, upper_d;
  logic [MaxWidth-1:0] middle_q, middle_d;
  logic                have_mid_q, have_mid_d;
  logic                accept;
  logic                last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= FrameWidthRst;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  assign eff_width = (width_q > CfgW'(MaxWidth)) ? CfgW'(MaxWidth) : width_q;

  always_comb begin
    for (int c = 0; c < MaxWidth; c++) begin
      mask[c] = (CfgW'(c) < eff_width);
    end
  end

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign last       = in_data_i.last_row;
  assign row        = in_data_i.pixel_row[MaxWidth-1:0] & mask;

  assign push_o              = accept & (have_mid_q | last);
  assign push_cmd_o.emit_row = have_mid_q;
  assign push_cmd_o.last     = last;
  assign push_row_o = upper_q & middle_q & row
                    & (upper_q << 1) & (upper_q >> 1)
                    & (middle_q << 1) & (middle_q >> 1)
                    & (row << 1) & (row >> 1)
                    & mask;

  always_comb begin
    upper_d    = upper_q;
    middle_d   = middle_q;
    have_mid_d = have_mid_q;
    if (accept) begin
      if (last) begin
        upper_d    = '0;
        middle_d   = '0;
        have_mid_d = 1'b0;
      end else if (have_mid_q) begin
        upper_d  = middle_q;
        middle_d = row;
      end else begin
        upper_d    = '0;
        middle_d   = row;
        have_mid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q    <= '0;
      middle_q   <= '0;
      have_mid_q <= 1'b0;
    end else begin
      upper_q    <= upper_d;
      middle_q   <= middle_d;
      have_mid_q <= have_mid_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ber_fifo.sv -----
`default_nettype none

module ber_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire logic [Width-1:0]               push_data_i,
  output      logic                           full_o,
  input  wire logic                           pop_i,
  output      logic [Width-1:0]               pop_data_o,
  output      logic                           empty_o,
  output      logic [$clog2(Depth+1)-1:0]     level_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [LvlW-1:0]  level_q;
  logic             do_push, do_pop;

  assign full_o     = (level_q == LvlW'(Depth));
  assign empty_o    = (level_q == '0);
  assign level_o    = level_q;
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + LvlW'(1);
      end else if (do_pop && !do_push) begin
        level_q <= level_q - LvlW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ber_back.sv -----
`default_nettype none

module ber_back import ber_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                empty_i,
  output      logic                pop_o,
  input  wire ber_cmd_t            pop_cmd_i,
  input  wire logic [MaxWidth-1:0] pop_row_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      ber_out_t            out_data_o,
  output      logic                pend_last_o
);

  logic     valid_q, valid_d;
  logic     pend_q, pend_d;
  ber_out_t out_q, out_d;
  logic     load;

  assign load = ~valid_q | out_ready_i;

  always_comb begin
    pop_o   = 1'b0;
    valid_d = valid_q;
    pend_d  = pend_q;
    out_d   = out_q;
    if (load) begin
      if (pend_q) begin
        // closing beat of the frame: last row erodes to zero
        valid_d          = 1'b1;
        pend_d           = 1'b0;
        out_d.eroded_row = '0;
        out_d.frame_end  = 1'b1;
      end else if (!empty_i) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        if (pop_cmd_i.emit_row) begin
          out_d.eroded_row = RowW'(pop_row_i);
          out_d.frame_end  = 1'b0;
          pend_d           = pop_cmd_i.last;
        end else begin
          out_d.eroded_row = '0;
          out_d.frame_end  = 1'b1;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = out_q;
  assign pend_last_o = pend_q;

endmodule

`default_nettype wire

// ----- sim/binary_erosion_3x3_rows_core_test.sv -----
`timescale 1ns / 100ps

module binary_erosion_3x3_rows_core_test;
  import ber_pkg::*;

  localparam int          ITEM_TOTAL  = 1550;
  localparam int          TAIL_ITEMS  = 150;
  localparam int          HOLD_CYCLES = 200;
  localparam int          STALL_LIMIT = 4000;
  localparam int          SETTLE      = 8;
  localparam int          NO_CFG      = -1;
  localparam logic [63:0] ONES        = '1;

  typedef struct {
    int          width_cfg;
    logic [63:0] px;
    bit          last;
    bit          typed;
    bit          gives_row;
    logic [63:0] want_row;
  } dir_row_t;

  dir_row_t dir_tab [23] = '{
    '{NO_CFG, ONES, 1'b1, 1'b1, 1'b0, 64'h0},
    '{NO_CFG, ONES, 1'b0, 1'b1, 1'b0, 64'h0},
    '{NO_CFG, ONES, 1'b0, 1'b1, 1'b1, 64'h0},
    '{NO_CFG, ONES, 1'b0, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE},
    '{NO_CFG, ONES, 1'b1, 1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE},
    '{0,      ONES, 1'b0, 1'b1, 1'b0, 64'h0},
    '{NO_CFG, ONES, 1'b0, 1'b1, 1'b1, 64'h0},
    '{NO_CFG, ONES, 1'b1, 1'b1, 1'b1, 64'h0},
    '{127,    64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 1'b0, 64'h0},
    '{NO_CFG, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 1'b0, 64'h0},
    '{NO_CFG, ONES, 1'b1, 1'b0, 1'b0, 64'h0},
    '{1,      ONES, 1'b0, 1'b1, 1'b0, 64'h0},
    '{NO_CFG, ONES, 1'b0, 1'b1, 1'b1, 64'h0},
    '{NO_CFG, ONES, 1'b1, 1'b1, 1'b1, 64'h0},
    '{3,      ONES, 1'b0, 1'b1, 1'b0, 64'h0},
    '{NO_CFG, ONES, 1'b0, 1'b1, 1'b1, 64'h0},
    '{NO_CFG, ONES, 1'b0, 1'b1, 1'b1, 64'h2},
    '{NO_CFG, 64'h0, 1'b1, 1'b1, 1'b1, 64'h0},
    '{64,     ONES, 1'b0, 1'b0, 1'b0, 64'h0},
    '{32,     ONES, 1'b0, 1'b0, 1'b0, 64'h0},
    '{NO_CFG, ONES, 1'b0, 1'b0, 1'b0, 64'h0},
    '{NO_CFG, 64'hFFFF_0000_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 64'h0},
    '{64,     64'h0, 1'b1, 1'b0, 1'b0, 64'h0}
  };

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;
  logic         in_valid_i;
  logic         in_ready_o;
  ber_in_t      in_data_i;
  logic         out_valid_o;
  logic         out_ready_i;
  ber_out_t     out_data_o;

  // predictor state
  logic [CfgW-1:0] width_cfg;
  logic [63:0]     above_row;
  logic [63:0]     centre_row;
  bit              centre_held;

  ber_out_t erosion_q [$];
  ber_out_t head_row;

  int  fail_cnt;
  int  items_sent;
  int  gap_pct;
  int  stall_pct;
  int  stall_left;
  int  epoch_left;
  int  hold_left;
  int  idle_cycles;
  bit  hold_req;
  bit  hold_done;
  bit  tail_mode;

  binary_erosion_3x3_rows_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Advance the row window by one input row; returns the number of output beats.
  function automatic int erode_next_rows(input logic [63:0] px, input bit last,
                                         output ber_out_t r0, output ber_out_t r1);
    int          lim;
    int          n;
    logic [63:0] mask;
    logic [63:0] below;
    logic [63:0] er;
    lim  = (width_cfg > MaxWidthDef) ? MaxWidthDef : width_cfg;
    mask = (lim >= 64) ? ONES : ((64'd1 << lim) - 64'd1);
    below = px & mask;
    n  = 0;
    r0 = '0;
    r1 = '0;
    if (centre_held) begin
      er = centre_row & above_row & below
         & (above_row << 1) & (above_row >> 1)
         & (centre_row << 1) & (centre_row >> 1)
         & (below << 1) & (below >> 1) & mask;
      r0 = '{eroded_row: er, frame_end: 1'b0};
      n  = 1;
    end
    if (last) begin
      if (n == 0) r0 = '{eroded_row: 64'h0, frame_end: 1'b1};
      else r1 = '{eroded_row: 64'h0, frame_end: 1'b1};
      n++;
      above_row   = '0;
      centre_row  = '0;
      centre_held = 1'b0;
    end else if (centre_held) begin
      above_row  = centre_row;
      centre_row = below;
    end else begin
      above_row   = '0;
      centre_row  = below;
      centre_held = 1'b1;
    end
    return n;
  endfunction

  function automatic logic [CfgW-1:0] pick_width();
    case ($urandom_range(7))
      0: return 7'd64;
      1: return 7'd1;
      2: return 7'd0;
      3: return 7'd127;
      4: return 7'($urandom_range(2, 4));
      5: return 7'($urandom_range(60, 66));
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // Only while idle: drain, let the pipeline settle, then write.
  task automatic write_width(input logic [CfgW-1:0] v);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (erosion_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    width_cfg = v;
  endtask

  task automatic send_row(input logic [63:0] px, input bit last, input bit typed,
                          input bit gives_row, input logic [63:0] want_row);
    int       gap;
    int       n;
    ber_out_t r0;
    ber_out_t r1;
    gap = 0;
    if (!tail_mode && !(hold_req && (!hold_done || hold_left != 0))
        && $urandom_range(99) < gap_pct)
      gap = $urandom_range(1, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{pixel_row: px, last_row: last};
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    n = erode_next_rows(px, last, r0, r1);
    if (typed) begin
      if (gives_row) erosion_q.push_back('{eroded_row: want_row, frame_end: 1'b0});
      if (last) erosion_q.push_back('{eroded_row: 64'h0, frame_end: 1'b1});
    end else begin
      if (n > 0) erosion_q.push_back(r0);
      if (n > 1) erosion_q.push_back(r1);
    end
  endtask

  // output beats: check, then decide ready for the next edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (erosion_q.size() == 0) begin
        $error("unexpected beat: eroded_row %h frame_end %b",
               out_data_o.eroded_row, out_data_o.frame_end);
        fail_cnt++;
      end else begin
        head_row = erosion_q.pop_front();
        if (out_data_o.eroded_row !== head_row.eroded_row) begin
          $error("eroded_row: expected %h, got %h", head_row.eroded_row,
                 out_data_o.eroded_row);
          fail_cnt++;
        end
        if (out_data_o.frame_end !== head_row.frame_end) begin
          $error("frame_end: expected %b, got %b", head_row.frame_end,
                 out_data_o.frame_end);
          fail_cnt++;
        end
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (epoch_left == 0) begin
        epoch_left = $urandom_range(64, 256);
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 5;
          2: stall_pct = 20;
          default: stall_pct = 45;
        endcase
      end else begin
        epoch_left--;
      end
      if (!tail_mode && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(0, 14);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [63:0] px;
    int          nrows;
    int          split;
    int          phase_frames;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    width_cfg   = FrameWidthRst;
    above_row   = '0;
    centre_row  = '0;
    centre_held = 1'b0;
    fail_cnt    = 0;
    items_sent  = 0;
    gap_pct     = 20;
    stall_pct   = 20;
    stall_left  = 0;
    epoch_left  = 0;
    hold_left   = 0;
    idle_cycles = 0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    tail_mode   = 1'b0;
    phase_frames = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].width_cfg != NO_CFG) write_width(7'(dir_tab[i].width_cfg));
      send_row(dir_tab[i].px, dir_tab[i].last, dir_tab[i].typed,
               dir_tab[i].gives_row, dir_tab[i].want_row);
    end

    while (items_sent < ITEM_TOTAL) begin
      if (phase_frames == 0 && !tail_mode) begin
        write_width(pick_width());
        phase_frames = $urandom_range(4, 12);
        // in the first phase only, the receiver holds off while rows keep coming, so the block backs up
        hold_req = 1'b1;
      end
      phase_frames--;
      case ($urandom_range(3))
        0: gap_pct = 0;
        1: gap_pct = 5;
        2: gap_pct = 20;
        default: gap_pct = 50;
      endcase
      case ($urandom_range(9))
        0: nrows = 1;
        1: nrows = $urandom_range(20, 40);
        default: nrows = $urandom_range(2, 10);
      endcase
      split = (nrows > 1 && $urandom_range(19) == 0) ? $urandom_range(1, nrows - 1) : 0;
      for (int r = 0; r < nrows; r++) begin
        if (split != 0 && r == split && !tail_mode) write_width(pick_width());
        case ($urandom_range(9))
          0, 1, 2: px = {$urandom, $urandom};
          3, 4, 5: px = ~({$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
          6, 7: px = ~({$urandom, $urandom} & {$urandom, $urandom}
                       & {$urandom, $urandom} & {$urandom, $urandom});
          8: px = ONES;
          default: px = 64'd1 << $urandom_range(0, 63);
        endcase
        send_row(px, r == nrows - 1, 1'b0, 1'b0, 64'h0);
        tail_mode = (items_sent >= ITEM_TOTAL - TAIL_ITEMS);
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (erosion_q.size() != 0);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ber_pkg.sv
rtl/core/ber_front.sv
rtl/core/ber_fifo.sv
rtl/core/ber_back.sv
rtl/core/binary_erosion_3x3_rows_core.sv
sim/binary_erosion_3x3_rows_core_test.sv
